// ===== src/bba_pkg.sv =====
// Package for the first-fit block allocator with file table.
// Holds operation and status codes, sequencer states and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int DISK_BLOCKS_DEF     = 1024;
	localparam int FILE_SLOTS_DEF      = 32;
	localparam int DIRECT_PER_FILE_DEF = 10;

	// Map words are 32 bits; a block is 2**19 bytes.
	localparam int MAP_W      = 32;
	localparam int MAP_IDX_W  = 5;
	localparam int BYTES_LOG2 = 19;
	localparam int TAG_W      = 64;

	typedef enum logic [2:0] {
		MODE_FORMAT = 3'd0,
		MODE_CREATE = 3'd1,
		MODE_GROW   = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_SHRINK = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DIR_FULL  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_OVER      = 3'd3,
		ST_BELOW     = 3'd4,
		ST_DISK_FULL = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CHK,
		S_ARD,
		S_ALD,
		S_APICK,
		S_RDL,
		S_RDM,
		S_RWR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                 found;
		logic [MAP_IDX_W-1:0] idx;
	} pick_t;

endpackage
`default_nettype wire

// ===== src/bba_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== src/bba_pick.sv =====
// First-free-bit finder over one 32-bit word of the block map.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_pick import bba_pkg::*; #(
	parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
	parameter int WA_W = 5
) (
	input  wire logic [MAP_W-1:0] word,
	input  wire logic [WA_W-1:0]  word_idx,
	output pick_t                 pick
);

	logic [WA_W+MAP_IDX_W:0] base;
	logic                    elig;

	// Bits past the end of the disk never count as free.
	always_comb begin
		base = {1'b0, word_idx, {MAP_IDX_W{1'b0}}};
		pick = '0;
		elig = 1'b0;
		for (int b = MAP_W - 1; b >= 0; b--) begin
			elig = (base + (WA_W+MAP_IDX_W+1)'(b)) < (WA_W+MAP_IDX_W+1)'(DISK_BLOCKS);
			if (elig && !word[b]) begin
				pick.found = 1'b1;
				pick.idx   = MAP_IDX_W'(b);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/bitmap_block_allocator_file_table.sv =====
// First-fit block allocator with file table. One request at a time.
// Format and create decide in the accept cycle; grow, delete and shrink search the name
// memory first. Allocation reads one 32-bit map word at a time (ARD, ALD, APICK) and
// takes free blocks from it; release reads the list, reads the map and writes it per block freed.
// Reset clears the map word valid bits, slot valid bits and totals at once; no clearing pass.
// Depends on bba_pkg, bba_ram and bba_pick.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_block_allocator_file_table import bba_pkg::*; #(
	parameter int DISK_BLOCKS     = DISK_BLOCKS_DEF,
	parameter int FILE_SLOTS      = FILE_SLOTS_DEF,
	parameter int DIRECT_PER_FILE = DIRECT_PER_FILE_DEF,
	localparam int SLOT_W = $clog2(FILE_SLOTS),
	localparam int INO_W  = $clog2(FILE_SLOTS + 1),
	localparam int BLK_W  = $clog2(DISK_BLOCKS),
	localparam int CNT_W  = $clog2(DIRECT_PER_FILE + 1),
	localparam int SIZE_W = CNT_W + BYTES_LOG2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        mode,
	input  wire logic [TAG_W-1:0]  name_tag,
	input  wire logic [CNT_W-1:0]  block_count,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [INO_W-1:0]       inode_number,
	output logic [BLK_W-1:0]       block_number,
	output logic [CNT_W-1:0]       blocks_held,
	output logic [SIZE_W-1:0]      size_bytes,
	output logic                   last
);

	localparam int MAP_WORDS = (DISK_BLOCKS + MAP_W - 1) / MAP_W;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int DL_DEPTH  = FILE_SLOTS * DIRECT_PER_FILE;
	localparam int DL_W      = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
	localparam int FREE_W    = $clog2(DISK_BLOCKS + 1);
	localparam int SCNT_W    = $clog2(FILE_SLOTS + 1);
	localparam int BX_W      = WA_W + MAP_IDX_W;

	state_t state_q, state_d;

	logic [2:0]        op_q;
	logic [TAG_W-1:0]  tag_q;
	logic [CNT_W-1:0]  n_q, held_q, got_q, k_q, kend_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WA_W-1:0]   w_q;
	logic [MAP_W-1:0]  wrd_q;
	logic [BLK_W-1:0]  rel_blk_q;
	logic [SCNT_W-1:0] srch_cnt_q;
	logic              srch_pend_s1;
	logic [SLOT_W-1:0] srch_idx_s1;
	logic [MAP_WORDS-1:0]  map_vld_q;
	logic [FILE_SLOTS-1:0] slot_vld_q;
	logic [CNT_W-1:0]  tot_q [FILE_SLOTS];
	logic [FREE_W-1:0] free_q;
	logic [2:0]        rsp_status_q;
	logic              rsp_live_q;
	logic [CNT_W-1:0]  rsp_held_q;

	// Memory ports.
	logic              map_we, name_we, dl_we;
	logic [WA_W-1:0]   map_addr;
	logic [MAP_W-1:0]  map_wdata, map_rdata;
	logic [SLOT_W-1:0] name_addr;
	logic [TAG_W-1:0]  name_rdata;
	logic [DL_W-1:0]   dl_addr;
	logic [BLK_W-1:0]  dl_wdata, dl_rdata;

	pick_t pick;

	logic              out_free;
	logic [CNT_W-1:0]  n_clamp;
	logic              fs_found;
	logic [SLOT_W-1:0] fs_idx;
	logic              srch_issue, srch_hit;
	logic [CNT_W-1:0]  chk_held;
	logic [CNT_W:0]    grow_sum;
	logic [BX_W-1:0]   rel_ext, pick_blk, rd_ext;
	logic [MAP_W-1:0]  rel_word;

	bba_ram #(.WIDTH(MAP_W), .DEPTH(MAP_WORDS)) u_map_ram (
		.clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
	);

	bba_ram #(.WIDTH(TAG_W), .DEPTH(FILE_SLOTS)) u_name_ram (
		.clk(clk), .we(name_we), .addr(name_addr), .wdata(name_tag), .rdata(name_rdata)
	);

	bba_ram #(.WIDTH(BLK_W), .DEPTH(DL_DEPTH)) u_list_ram (
		.clk(clk), .we(dl_we), .addr(dl_addr), .wdata(dl_wdata), .rdata(dl_rdata)
	);

	bba_pick #(.DISK_BLOCKS(DISK_BLOCKS), .WA_W(WA_W)) u_pick (
		.word(wrd_q), .word_idx(w_q), .pick(pick)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		n_clamp = (block_count > CNT_W'(DIRECT_PER_FILE)) ? CNT_W'(DIRECT_PER_FILE)
			: block_count;
		fs_found = 1'b0;
		fs_idx   = '0;
		for (int i = FILE_SLOTS - 1; i >= 0; i--) begin
			if (!slot_vld_q[i]) begin
				fs_found = 1'b1;
				fs_idx   = SLOT_W'(i);
			end
		end
	end

	assign srch_issue = (srch_cnt_q < SCNT_W'(FILE_SLOTS));
	assign srch_hit   = srch_pend_s1 && slot_vld_q[srch_idx_s1] && (name_rdata == tag_q);
	assign chk_held   = tot_q[slot_q];
	assign grow_sum   = {1'b0, chk_held} + {1'b0, n_q};
	assign rel_ext    = BX_W'(rel_blk_q);
	assign rd_ext     = BX_W'(dl_rdata);
	assign pick_blk   = {w_q, pick.idx};
	assign rel_word   = (map_vld_q[rel_ext[BX_W-1:MAP_IDX_W]] ? map_rdata : '0)
		& ~(MAP_W'(1) << rel_ext[MAP_IDX_W-1:0]);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority case (mode)
						MODE_FORMAT: state_d = S_RESP;
						MODE_CREATE: begin
							if (n_clamp == '0 || !fs_found
								|| free_q < FREE_W'(n_clamp)) begin
								state_d = S_RESP;
							end else begin
								state_d = S_ARD;
							end
						end
						MODE_GROW, MODE_DELETE, MODE_SHRINK: state_d = S_SRCH;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SRCH: begin
				if (srch_hit) begin
					state_d = S_CHK;
				end else if (!srch_issue && !srch_pend_s1) begin
					state_d = S_RESP;
				end
			end
			S_CHK: begin
				priority case (op_q)
					MODE_GROW: begin
						if (grow_sum > (CNT_W+1)'(DIRECT_PER_FILE)
							|| free_q < FREE_W'(n_q) || n_q == '0) begin
							state_d = S_RESP;
						end else begin
							state_d = S_ARD;
						end
					end
					MODE_DELETE: state_d = (chk_held == '0) ? S_RESP : S_RDL;
					default: begin
						if ({1'b0, n_q} + 1'b1 > {1'b0, chk_held} || n_q == '0) begin
							state_d = S_RESP;
						end else begin
							state_d = S_RDL;
						end
					end
				endcase
			end
			S_ARD:   state_d = S_ALD;
			S_ALD:   state_d = S_APICK;
			S_APICK: begin
				if (!pick.found) begin
					state_d = S_ARD;
				end else if (out_free && got_q + 1'b1 == n_q) begin
					state_d = S_IDLE;
				end
			end
			S_RDL:   state_d = S_RDM;
			S_RDM:   state_d = S_RWR;
			S_RWR:   state_d = (k_q + 1'b1 == kend_q) ? S_RESP : S_RDL;
			S_RESP:  state_d = out_free ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		map_we    = 1'b0;
		map_addr  = w_q;
		map_wdata = wrd_q | (MAP_W'(1) << pick.idx);
		name_we   = 1'b0;
		name_addr = srch_cnt_q[SLOT_W-1:0];
		dl_we     = 1'b0;
		dl_addr   = DL_W'(slot_q) * DL_W'(DIRECT_PER_FILE) + DL_W'(held_q);
		dl_wdata  = pick_blk[BLK_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				name_addr = fs_idx;
				name_we   = in_valid && mode == MODE_CREATE && n_clamp != '0 && fs_found
					&& free_q >= FREE_W'(n_clamp);
			end
			S_APICK: begin
				map_we = pick.found && out_free;
				dl_we  = pick.found && out_free;
			end
			S_RDL: begin
				dl_addr = DL_W'(slot_q) * DL_W'(DIRECT_PER_FILE) + DL_W'(k_q);
			end
			S_RDM: begin
				map_addr = rd_ext[BX_W-1:MAP_IDX_W];
			end
			S_RWR: begin
				map_addr  = rel_ext[BX_W-1:MAP_IDX_W];
				map_wdata = rel_word;
				map_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			map_vld_q    <= '0;
			slot_vld_q   <= '0;
			free_q       <= FREE_W'(DISK_BLOCKS);
			out_valid    <= 1'b0;
			srch_pend_s1 <= 1'b0;
			for (int i = 0; i < FILE_SLOTS; i++) begin
				tot_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					op_q       <= mode;
					tag_q      <= name_tag;
					n_q        <= block_count;
					srch_cnt_q <= '0;
					srch_pend_s1 <= 1'b0;
					slot_q     <= '0;
					rsp_live_q <= 1'b0;
					rsp_held_q <= '0;
					held_q     <= '0;
					got_q      <= '0;
					w_q        <= '0;
					rsp_status_q <= ST_OK;
					if (in_valid && mode == MODE_FORMAT) begin
						map_vld_q  <= '0;
						slot_vld_q <= '0;
						free_q     <= FREE_W'(DISK_BLOCKS);
						for (int i = 0; i < FILE_SLOTS; i++) begin
							tot_q[i] <= '0;
						end
					end else if (in_valid && mode == MODE_CREATE) begin
						n_q <= n_clamp;
						if (n_clamp == '0) begin
							rsp_status_q <= ST_BELOW;
						end else if (!fs_found) begin
							rsp_status_q <= ST_DIR_FULL;
						end else if (free_q < FREE_W'(n_clamp)) begin
							rsp_status_q <= ST_DISK_FULL;
						end else begin
							slot_vld_q[fs_idx] <= 1'b1;
							tot_q[fs_idx]      <= '0;
							slot_q             <= fs_idx;
						end
					end
				end
				S_SRCH: begin
					srch_pend_s1 <= srch_issue && !srch_hit;
					srch_idx_s1  <= srch_cnt_q[SLOT_W-1:0];
					if (srch_issue) begin
						srch_cnt_q <= srch_cnt_q + 1'b1;
					end
					if (srch_hit) begin
						slot_q <= srch_idx_s1;
					end else if (!srch_issue && !srch_pend_s1) begin
						rsp_status_q <= ST_NOT_FOUND;
					end
				end
				S_CHK: begin
					rsp_live_q <= 1'b1;
					rsp_held_q <= chk_held;
					held_q     <= chk_held;
					priority case (op_q)
						MODE_GROW: begin
							if (grow_sum > (CNT_W+1)'(DIRECT_PER_FILE)) begin
								rsp_status_q <= ST_OVER;
							end else if (free_q < FREE_W'(n_q)) begin
								rsp_status_q <= ST_DISK_FULL;
							end
						end
						MODE_DELETE: begin
							slot_vld_q[slot_q] <= 1'b0;
							tot_q[slot_q]      <= '0;
							rsp_live_q         <= 1'b0;
							rsp_held_q         <= '0;
							k_q                <= '0;
							kend_q             <= chk_held;
						end
						default: begin
							if ({1'b0, n_q} + 1'b1 > {1'b0, chk_held}) begin
								rsp_status_q <= ST_BELOW;
							end else begin
								tot_q[slot_q] <= chk_held - n_q;
								rsp_held_q    <= chk_held - n_q;
								k_q           <= chk_held - n_q;
								kend_q        <= chk_held;
							end
						end
					endcase
				end
				S_ARD: begin
				end
				S_ALD: begin
					wrd_q <= map_vld_q[w_q] ? map_rdata : '0;
				end
				S_APICK: begin
					if (!pick.found) begin
						w_q <= w_q + 1'b1;
					end else if (out_free) begin
						wrd_q          <= map_wdata;
						map_vld_q[w_q] <= 1'b1;
						held_q         <= held_q + 1'b1;
						got_q          <= got_q + 1'b1;
						tot_q[slot_q]  <= held_q + 1'b1;
						free_q         <= free_q - 1'b1;
						out_valid      <= 1'b1;
						status         <= ST_OK;
						slot           <= slot_q;
						inode_number   <= INO_W'(slot_q) + 1'b1;
						block_number   <= pick_blk[BLK_W-1:0];
						blocks_held    <= held_q + 1'b1;
						size_bytes     <= SIZE_W'(held_q + 1'b1) << BYTES_LOG2;
						last           <= (got_q + 1'b1 == n_q);
					end
				end
				S_RDL: begin
				end
				S_RDM: begin
					rel_blk_q <= dl_rdata;
				end
				S_RWR: begin
					map_vld_q[rel_ext[BX_W-1:MAP_IDX_W]] <= 1'b1;
					free_q <= free_q + 1'b1;
					k_q    <= k_q + 1'b1;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						status       <= rsp_status_q;
						slot         <= slot_q;
						inode_number <= rsp_live_q ? INO_W'(slot_q) + 1'b1 : '0;
						block_number <= '0;
						blocks_held  <= rsp_held_q;
						size_bytes   <= SIZE_W'(rsp_held_q) << BYTES_LOG2;
						last         <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The free count can never pass the disk size.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(DISK_BLOCKS))
		else $error("free block count above disk size");

	// A block is only marked used when an output register is free to report it.
	a_alloc_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APICK && map_we) |=> (out_valid && block_number == $past(pick_blk[BLK_W-1:0])))
		else $error("allocated block not reported");

	// Allocation only starts with enough free blocks for the whole request.
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE || state_q == S_CHK) && state_d == S_ARD)
		|=> (free_q >= FREE_W'(n_q)))
		else $error("allocation started without room");

endmodule
`default_nettype wire
